// File: rtl/ttg_pkg.sv
// ttg_pkg: shared types and constants for the triangle tangent generator
// used by every module of the block, depends on nothing

package ttg_pkg;

   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int IDX_W    = 16;
   localparam int POS_W    = 32;
   localparam int DELTA_W  = 33;
   localparam int PROD_W   = 66;
   localparam int MAG_W    = 66;
   localparam int NORM_W   = 30;
   localparam int SUM_W    = 62;
   localparam int ROOT_W   = 64;
   localparam int LEN_W    = 31;
   localparam int TAN_W    = 18;
   localparam int FRAC_W   = 16;
   localparam int STEP_W   = 5;
   localparam int MUL_LAST = 9;
   localparam int SQR_LAST = 3;
   localparam int DIV_LAST = 19;
   localparam int REQ_W    = ((IDX_W + 5 * POS_W + 7) / 8) * 8;
   localparam int RSP_W    = ((IDX_W + 3 * TAN_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_SQR,
      ST_ROOT,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// File: rtl/ttg_mul.sv
// ttg_mul: shared signed multiplier with a registered product
// depends on ttg_pkg for operand and product widths

module ttg_mul (
   input  logic                                clock,
   input  logic signed [ttg_pkg::DELTA_W-1:0] mul_a,
   input  logic signed [ttg_pkg::DELTA_W-1:0] mul_b,
   output logic signed [ttg_pkg::PROD_W-1:0]  mul_p
);

   logic signed [ttg_pkg::PROD_W-1:0] product_ff;
   logic signed [ttg_pkg::PROD_W-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign mul_p = product_ff;

endmodule

// File: rtl/triangle_tangent_generator_core.sv
// Per-triangle tangent generator. Corners arrive one beat each; the first two corners of a
// triangle are stored as they are accepted. Accepting the third starts a sequencer that runs
// one shared multiplier, a bit-serial square root and a bit-serial divider: products,
// normalizing shifts, squares, square root and division of each of the three components,
// then three result beats. Degenerate triangles skip from the products straight to output.
// The input is not ready while a triangle is in work. Only the low INDEX_BITS bits of
// vertex_index are kept.
// Depends on ttg_pkg and ttg_mul.

module triangle_tangent_generator_core #(
   parameter int INDEX_BITS = ttg_pkg::INDEX_BITS_DEFAULT,
   localparam int REQ_W = ttg_pkg::REQ_W,
   localparam int RSP_W = ttg_pkg::RSP_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // target_index, tangent_x, tangent_y, tangent_z
   output logic [RSP_W-1:0] rsp_tdata,
   // handedness_negative, degenerate
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int DW = ttg_pkg::DELTA_W;
   localparam int PW = ttg_pkg::POS_W;
   localparam int MW = ttg_pkg::MAG_W;
   localparam int NW = ttg_pkg::NORM_W;
   localparam int TW = ttg_pkg::TAN_W;
   localparam int LW = ttg_pkg::LEN_W;
   localparam int RW = ttg_pkg::ROOT_W;
   localparam int SW = ttg_pkg::STEP_W;
   localparam int IW = ttg_pkg::IDX_W;
   localparam int IDX_KEEP = (INDEX_BITS < IW) ? INDEX_BITS : IW;
   localparam logic [IW-1:0] IDX_MASK = IW'((64'd1 << IDX_KEEP) - 64'd1);

   ttg_pkg::state_type state_ff, state_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [1:0]            beat_ff, beat_in;
   logic [IW-1:0]         idx_ff [3];
   logic [IW-1:0]         idx_in [3];
   logic signed [PW-1:0]  pos0_ff [3];
   logic signed [PW-1:0]  pos0_in [3];
   logic signed [PW-1:0]  pos1_ff [3];
   logic signed [PW-1:0]  pos1_in [3];
   logic signed [PW-1:0]  tex0_ff [2];
   logic signed [PW-1:0]  tex0_in [2];
   logic signed [PW-1:0]  tex1_ff [2];
   logic signed [PW-1:0]  tex1_in [2];
   logic signed [DW-1:0]  dp1_ff [3];
   logic signed [DW-1:0]  dp1_in [3];
   logic signed [DW-1:0]  dp2_ff [3];
   logic signed [DW-1:0]  dp2_in [3];
   logic signed [DW-1:0]  du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic [SW-1:0]         step_ff, step_in;
   logic signed [ttg_pkg::PROD_W-1:0] hold_ff, hold_in;
   logic                  det_neg_ff, det_neg_in, det_zero_ff, det_zero_in;
   logic [MW-1:0]         cmag_ff [3];
   logic [MW-1:0]         cmag_in [3];
   logic                  cneg_ff [3];
   logic                  cneg_in [3];
   logic [ttg_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [RW-1:0]         rn_ff, rn_in, rr_ff, rr_in, rb_ff, rb_in;
   logic [31:0]           rem_ff, rem_in;
   logic [TW-1:0]         num_ff, num_in, quo_ff, quo_in;
   logic [1:0]            comp_ff, comp_in;
   logic signed [TW-1:0]  tan_ff [3];
   logic signed [TW-1:0]  tan_in [3];
   logic                  degen_ff, degen_in, hneg_ff, hneg_in;

   logic signed [DW-1:0]  mul_a, mul_b;
   logic signed [ttg_pkg::PROD_W-1:0] mul_p;

   logic [IW-1:0]         r_idx;
   logic signed [PW-1:0]  r_pos [3];
   logic signed [PW-1:0]  r_tex [2];
   logic [SW-1:0]         prev;
   logic signed [MW:0]    diff;
   logic [MW:0]           diff_abs;
   logic [MW-1:0]         orv;
   logic [RW-1:0]         rt;
   logic [46:0]           numer;
   logic [31:0]           dt, dl;
   logic [NW-1:0]         msel;

   assign r_idx = req_tdata[IW-1:0] & IDX_MASK;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_pos[i] = req_tdata[IW + PW*i +: PW];
      end
      for (int i = 0; i < 2; i++) begin
         r_tex[i] = req_tdata[IW + PW*(3+i) +: PW];
      end
   end

   ttg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign prev     = step_ff - SW'(1);
   assign diff     = {hold_ff[ttg_pkg::PROD_W-1], hold_ff} - {mul_p[ttg_pkg::PROD_W-1], mul_p};
   assign diff_abs = diff[MW] ? (MW+1)'(-diff) : diff;
   assign orv      = cmag_ff[0] | cmag_ff[1] | cmag_ff[2];
   assign rt       = rr_ff + rb_ff;
   assign msel     = cmag_ff[comp_ff][MW-1 -: NW];
   assign numer    = {1'b0, msel, {ttg_pkg::FRAC_W{1'b0}}} + 47'(rr_ff[LW-1:1]);
   assign dt       = {rem_ff[30:0], num_ff[TW-1]};
   assign dl       = {1'b0, rr_ff[LW-1:0]};

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      beat_in     = beat_ff;
      idx_in      = idx_ff;
      pos0_in     = pos0_ff;
      pos1_in     = pos1_ff;
      tex0_in     = tex0_ff;
      tex1_in     = tex1_ff;
      dp1_in      = dp1_ff;
      dp2_in      = dp2_ff;
      du1_in      = du1_ff;
      dv1_in      = dv1_ff;
      du2_in      = du2_ff;
      dv2_in      = dv2_ff;
      step_in     = step_ff;
      hold_in     = hold_ff;
      det_neg_in  = det_neg_ff;
      det_zero_in = det_zero_ff;
      cmag_in     = cmag_ff;
      cneg_in     = cneg_ff;
      sum_in      = sum_ff;
      rn_in       = rn_ff;
      rr_in       = rr_ff;
      rb_in       = rb_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      comp_in     = comp_ff;
      tan_in      = tan_ff;
      degen_in    = degen_ff;
      hneg_in     = hneg_ff;
      mul_a       = '0;
      mul_b       = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      unique case (state_ff)
         ttg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (cnt_ff == 2'd0) begin
                  pos0_in   = r_pos;
                  tex0_in   = r_tex;
                  idx_in[0] = r_idx;
                  cnt_in    = 2'd1;
               end else if (cnt_ff == 2'd1) begin
                  pos1_in   = r_pos;
                  tex1_in   = r_tex;
                  idx_in[1] = r_idx;
                  cnt_in    = 2'd2;
               end else begin
                  idx_in[2] = r_idx;
                  cnt_in    = 2'd0;
                  for (int i = 0; i < 3; i++) begin
                     dp1_in[i] = DW'(pos1_ff[i]) - DW'(pos0_ff[i]);
                     dp2_in[i] = DW'(r_pos[i]) - DW'(pos0_ff[i]);
                  end
                  du1_in   = DW'(tex1_ff[0]) - DW'(tex0_ff[0]);
                  dv1_in   = DW'(tex1_ff[1]) - DW'(tex0_ff[1]);
                  du2_in   = DW'(r_tex[0]) - DW'(tex0_ff[0]);
                  dv2_in   = DW'(r_tex[1]) - DW'(tex0_ff[1]);
                  step_in  = '0;
                  state_in = ttg_pkg::ST_MUL;
               end
            end
         end

         ttg_pkg::ST_MUL: begin
            unique case (step_ff)
               5'd0: begin mul_a = du1_ff; mul_b = dv2_ff; end
               5'd1: begin mul_a = du2_ff; mul_b = dv1_ff; end
               5'd2: begin mul_a = dv2_ff; mul_b = dp1_ff[0]; end
               5'd3: begin mul_a = dv1_ff; mul_b = dp2_ff[0]; end
               5'd4: begin mul_a = dv2_ff; mul_b = dp1_ff[1]; end
               5'd5: begin mul_a = dv1_ff; mul_b = dp2_ff[1]; end
               5'd6: begin mul_a = dv2_ff; mul_b = dp1_ff[2]; end
               5'd7: begin mul_a = dv1_ff; mul_b = dp2_ff[2]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            if (step_ff != '0 && step_ff != SW'(ttg_pkg::MUL_LAST)) begin
               if (!prev[0]) begin
                  hold_in = mul_p;
               end else if (prev[2:1] == 2'd0) begin
                  det_zero_in = (diff == '0);
                  det_neg_in  = diff[MW];
               end else begin
                  cmag_in[prev[2:1] - 2'd1] = diff_abs[MW-1:0];
                  cneg_in[prev[2:1] - 2'd1] = (diff[MW] ^ det_neg_ff) && (diff != '0);
               end
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(ttg_pkg::MUL_LAST)) begin
               hneg_in  = !det_zero_ff && !det_neg_ff;
               degen_in = det_zero_ff || (orv == '0);
               for (int i = 0; i < 3; i++) begin
                  tan_in[i] = '0;
               end
               beat_in  = 2'd0;
               state_in = (det_zero_ff || (orv == '0)) ? ttg_pkg::ST_OUT : ttg_pkg::ST_NORM;
            end
         end

         ttg_pkg::ST_NORM: begin
            step_in = '0;
            sum_in  = '0;
            if (orv[MW-1]) begin
               state_in = ttg_pkg::ST_SQR;
            end else if (orv[MW-1 -: 4] == 4'd0) begin
               for (int i = 0; i < 3; i++) begin
                  cmag_in[i] = cmag_ff[i] << 4;
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  cmag_in[i] = cmag_ff[i] << 1;
               end
            end
         end

         ttg_pkg::ST_SQR: begin
            unique case (step_ff)
               5'd0: begin
                  mul_a = DW'(cmag_ff[0][MW-1 -: NW]);
                  mul_b = DW'(cmag_ff[0][MW-1 -: NW]);
               end
               5'd1: begin
                  mul_a = DW'(cmag_ff[1][MW-1 -: NW]);
                  mul_b = DW'(cmag_ff[1][MW-1 -: NW]);
               end
               5'd2: begin
                  mul_a = DW'(cmag_ff[2][MW-1 -: NW]);
                  mul_b = DW'(cmag_ff[2][MW-1 -: NW]);
               end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            if (step_ff != '0) begin
               sum_in = sum_ff + mul_p[ttg_pkg::SUM_W-1:0];
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(ttg_pkg::SQR_LAST)) begin
               rn_in    = RW'(sum_ff + mul_p[ttg_pkg::SUM_W-1:0]);
               rr_in    = '0;
               rb_in    = RW'(1) << 62;
               state_in = ttg_pkg::ST_ROOT;
            end
         end

         ttg_pkg::ST_ROOT: begin
            if (rn_ff >= rt) begin
               rn_in = rn_ff - rt;
               rr_in = (rr_ff >> 1) + rb_ff;
            end else begin
               rr_in = rr_ff >> 1;
            end
            rb_in = rb_ff >> 2;
            if (rb_ff[0]) begin
               comp_in  = 2'd0;
               step_in  = '0;
               state_in = ttg_pkg::ST_DIV;
            end
         end

         ttg_pkg::ST_DIV: begin
            step_in = step_ff + SW'(1);
            if (step_ff == '0) begin
               rem_in = 32'(numer[46:TW]);
               num_in = numer[TW-1:0];
               quo_in = '0;
            end else if (step_ff == SW'(ttg_pkg::DIV_LAST)) begin
               tan_in[comp_ff] = cneg_ff[comp_ff] ? TW'(-quo_ff) : quo_ff;
               step_in = '0;
               comp_in = comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  beat_in  = 2'd0;
                  state_in = ttg_pkg::ST_OUT;
               end
            end else begin
               num_in = num_ff << 1;
               if (dt >= dl) begin
                  rem_in = dt - dl;
                  quo_in = {quo_ff[TW-2:0], 1'b1};
               end else begin
                  rem_in = dt;
                  quo_in = {quo_ff[TW-2:0], 1'b0};
               end
            end
         end

         ttg_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               beat_in = beat_ff + 2'd1;
               if (beat_ff == 2'd2) begin
                  beat_in  = 2'd0;
                  state_in = ttg_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ttg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = RSP_W'({tan_ff[2], tan_ff[1], tan_ff[0], idx_ff[beat_ff]});
   assign rsp_tuser = {degen_ff, hneg_ff};
   assign rsp_tlast = (beat_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttg_pkg::ST_IDLE;
         cnt_ff   <= 2'd0;
         beat_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos0_ff     <= pos0_in;
      pos1_ff     <= pos1_in;
      tex0_ff     <= tex0_in;
      tex1_ff     <= tex1_in;
      dp1_ff      <= dp1_in;
      dp2_ff      <= dp2_in;
      du1_ff      <= du1_in;
      dv1_ff      <= dv1_in;
      du2_ff      <= du2_in;
      dv2_ff      <= dv2_in;
      step_ff     <= step_in;
      hold_ff     <= hold_in;
      det_neg_ff  <= det_neg_in;
      det_zero_ff <= det_zero_in;
      cmag_ff     <= cmag_in;
      cneg_ff     <= cneg_in;
      sum_ff      <= sum_in;
      rn_ff       <= rn_in;
      rr_ff       <= rr_in;
      rb_ff       <= rb_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      comp_ff     <= comp_in;
      tan_ff      <= tan_in;
      degen_ff    <= degen_in;
      hneg_ff     <= hneg_in;
   end

endmodule

// File: rtl/ttg_checker.sv
// ttg_checker: port-level assertions for the tangent generator
// depends on ttg_pkg, bound to triangle_tangent_generator_core

module ttg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [ttg_pkg::REQ_W-1:0]   req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ttg_pkg::RSP_W-1:0]   rsp_tdata,
   input logic [1:0]                  rsp_tuser,
   input logic                        rsp_tlast
);

   localparam int TANS = 3 * ttg_pkg::TAN_W;

   logic [TANS-1:0] tans;
   assign tans = rsp_tdata[ttg_pkg::IDX_W +: TANS];

   a_beat_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> tans == '0)
      else $error("degenerate beat with nonzero tangent");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> tans != '0)
      else $error("valid tangent is zero");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("beat after last of triangle");

endmodule

bind triangle_tangent_generator_core ttg_checker u_ttg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
